FILE: src/rr_pkg.sv
// ----------------------------------------------------------------------------
// rr_pkg: shared types and codes for the fraction reduction block
// Kind and status codes, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rr_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // operation selector carried in s_tuser
    localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INVERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABS    = 2'd2;

    // result status carried in m_tuser
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BOTH_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture a new beat
        logic gcd_step;  // one binary gcd step
        logic div_init;  // latch divisor, clear remainders
        logic div_step;  // one restoring division step
        logic out_load;  // write the output register
    } rr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic gcd_done;  // one operand reached zero
        logic skip_div;  // divisor zero or not representable
        logic div_last;  // final quotient bit in this step
    } rr_sts_t;

endpackage

FILE: src/rr_datapath.sv
// ----------------------------------------------------------------------------
// rr_datapath: operand registers, binary gcd and twin restoring divider
// Magnitudes are reduced by a shared subtract/shift gcd unit, then both are
// divided by the gcd one quotient bit per cycle. Holds the output register.
// ----------------------------------------------------------------------------
module rr_datapath
    import rr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic [KIND_W-1:0]     kind_in,
    input  logic [DATA_WIDTH-1:0] num_in,
    input  logic [DATA_WIDTH-1:0] den_in,
    input  rr_cmd_t               cmd,
    output rr_sts_t               sts,
    output logic [DATA_WIDTH-1:0] out_num,
    output logic [DATA_WIDTH-1:0] out_den,
    output logic [STATUS_W-1:0]   out_status
);

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic [W-1:0]        a_reg, a_next;
    logic [W-1:0]        b_reg, b_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [W-1:0]        dvs_reg;
    logic [W-1:0]        qn_reg, qn_next;
    logic [W-1:0]        qd_reg, qd_next;
    logic [W-1:0]        rn_reg, rn_next;
    logic [W-1:0]        rd_reg, rd_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                sn_reg, sd_reg, abs_reg;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [W-1:0]        out_num_reg, out_num_next;
    logic [W-1:0]        out_den_reg, out_den_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [W-1:0]        n_sel, d_sel, an, ad;
    logic [W-1:0]        g_odd, gm;
    logic [W-1:0]        diff_ab, diff_ba;
    logic [W:0]          rn_sh, rd_sh, rn_sub, rd_sub;
    logic                num_neg, q_ovf;

    // operand swap for inversion, then magnitudes
    always_comb begin
        n_sel = (kind_in == KIND_INVERT) ? den_in : num_in;
        d_sel = (kind_in == KIND_INVERT) ? num_in : den_in;
        an    = n_sel[W-1] ? (W'(0) - n_sel) : n_sel;
        ad    = d_sel[W-1] ? (W'(0) - d_sel) : d_sel;
    end

    // gcd: the remaining nonzero operand times the common power of two
    assign g_odd   = a_reg | b_reg;
    assign gm      = g_odd << k_reg;
    assign diff_ab = a_reg - b_reg;
    assign diff_ba = b_reg - a_reg;

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (cmd.load) begin
            a_next = an;
            b_next = ad;
            k_next = '0;
        end else if (cmd.gcd_step) begin
            if (!a_reg[0] && !b_reg[0]) begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else if (a_reg >= b_reg) begin
                a_next = diff_ab >> 1;
            end else begin
                b_next = diff_ba >> 1;
            end
        end
    end

    // restoring division of both magnitudes by the gcd
    assign rn_sh  = {rn_reg, qn_reg[W-1]};
    assign rd_sh  = {rd_reg, qd_reg[W-1]};
    assign rn_sub = rn_sh - {1'b0, dvs_reg};
    assign rd_sub = rd_sh - {1'b0, dvs_reg};

    always_comb begin
        qn_next = qn_reg;
        qd_next = qd_reg;
        rn_next = rn_reg;
        rd_next = rd_reg;
        if (cmd.load) begin
            qn_next = an;
            qd_next = ad;
        end else if (cmd.div_init) begin
            rn_next = '0;
            rd_next = '0;
        end else if (cmd.div_step) begin
            qn_next = {qn_reg[W-2:0], ~rn_sub[W]};
            qd_next = {qd_reg[W-2:0], ~rd_sub[W]};
            rn_next = rn_sub[W] ? rn_sh[W-1:0] : rn_sub[W-1:0];
            rd_next = rd_sub[W] ? rd_sh[W-1:0] : rd_sub[W-1:0];
        end
    end

    // early status once the gcd is known
    always_comb begin
        if (gm == '0) begin
            err_next = STATUS_BOTH_ZERO;
        end else if (gm[W-1]) begin
            err_next = STATUS_OVERFLOW;
        end else begin
            err_next = STATUS_OK;
        end
    end

    // sign and range of the quotients
    assign num_neg = (sn_reg != sd_reg) && (qn_reg != '0) && !abs_reg;
    assign q_ovf   = (!num_neg && qn_reg[W-1]) || qd_reg[W-1];

    always_comb begin
        out_num_next    = out_num_reg;
        out_den_next    = out_den_reg;
        out_status_next = out_status_reg;
        if (cmd.out_load) begin
            if (err_reg != STATUS_OK) begin
                out_num_next    = '0;
                out_den_next    = '0;
                out_status_next = err_reg;
            end else if (q_ovf) begin
                out_num_next    = '0;
                out_den_next    = '0;
                out_status_next = STATUS_OVERFLOW;
            end else begin
                out_num_next    = num_neg ? (W'(0) - qn_reg) : qn_reg;
                out_den_next    = qd_reg;
                out_status_next = STATUS_OK;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        k_reg          <= k_next;
        qn_reg         <= qn_next;
        qd_reg         <= qd_next;
        rn_reg         <= rn_next;
        rd_reg         <= rd_next;
        out_num_reg    <= out_num_next;
        out_den_reg    <= out_den_next;
        out_status_reg <= out_status_next;
        if (cmd.load) begin
            sn_reg  <= n_sel[W-1];
            sd_reg  <= d_sel[W-1];
            abs_reg <= (kind_in == KIND_ABS);
        end
        if (cmd.div_init) begin
            dvs_reg <= gm;
            err_reg <= err_next;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign sts.gcd_done = (a_reg == '0) || (b_reg == '0);
    assign sts.skip_div = (err_next != STATUS_OK);
    assign sts.div_last = (cnt_reg == CNT_W'(DATA_WIDTH - 1));

    assign out_num    = out_num_reg;
    assign out_den    = out_den_reg;
    assign out_status = out_status_reg;

endmodule

FILE: src/rr_ctrl.sv
// ----------------------------------------------------------------------------
// rr_ctrl: sequencer for the fraction reduction block
// Steps the gcd until an operand is zero, runs the divider for one bit per
// cycle (skipped on error), then loads the output register once it is free.
// ----------------------------------------------------------------------------
module rr_ctrl
    import rr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output rr_cmd_t cmd,
    input  rr_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;

    // command decode
    always_comb begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.gcd_step = (state_reg == ST_GCD) && !sts.gcd_done;
        cmd.div_init = (state_reg == ST_GCD) && sts.gcd_done;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.out_load = (state_reg == ST_DONE) && out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_GCD;
            end
            ST_GCD: begin
                if (sts.gcd_done) state_next = sts.skip_div ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output beat valid
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

FILE: src/rational_reduce.sv
// ----------------------------------------------------------------------------
// rational_reduce: signed fraction to lowest terms
// Input beat: s_tdata = {denominator, numerator}, s_tuser = kind (reduce,
// invert then reduce, reduce then absolute value). Output beat: m_tdata =
// {reduced_denominator, reduced_numerator}, m_tuser = status (ok, both zero,
// overflow). Each beat gets exactly one result beat, and the result
// denominator is never negative. Error results carry zero values.
// Work runs in order: capture, binary gcd steps on the shared subtract/shift
// unit, a setup step that latches the gcd as divisor, restoring division
// (both quotients in parallel, one bit each per cycle), and the write into
// the output register. Division is skipped on error.
// One beat is in work at a time; s_tready is high only while idle.
// The result waits in the output register; a new beat may be accepted and
// worked while it waits, and the finished one holds until the register frees.
// Reset (aresetn low, synchronous) drops any beat in work and clears m_tvalid.
// ----------------------------------------------------------------------------
module rational_reduce
    import rr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // numerator, denominator, zero padding to whole bytes
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    s_tdata,
    // kind
    input  logic [KIND_W-1:0]                    s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // reduced_numerator, reduced_denominator, zero padding to whole bytes
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
    // status
    output logic [STATUS_W-1:0]                  m_tuser
);

    localparam int TDATA_W = ((2*DATA_WIDTH+7)/8)*8;

    rr_cmd_t               cmd;
    rr_sts_t               sts;
    logic [DATA_WIDTH-1:0] out_num, out_den;

    rr_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .kind_in    (s_tuser),
        .num_in     (s_tdata[DATA_WIDTH-1:0]),
        .den_in     (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .cmd        (cmd),
        .sts        (sts),
        .out_num    (out_num),
        .out_den    (out_den),
        .out_status (m_tuser)
    );

    rr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    assign m_tdata = TDATA_W'({out_den, out_num});

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for rational_reduce
// Drives signed fractions with a kind selector over the slave stream and
// checks every result beat against a typed row or a lowest-terms predictor.
// A short table of corner cases runs first. Random fractions follow: shared
// factors, powers of two, small and extreme values, and full-range noise.
// Both sides stall at random, with one calm window and one long output hold.
// ----------------------------------------------------------------------------
module tb;
    import rr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW          = 32;
    localparam int TDATA_W     = ((2*DW+7)/8)*8;
    localparam int N_DIR       = 25;
    localparam int N_RANDOM    = 630;
    localparam int CALM_FROM   = 150;   // beats sent before the no-stall window
    localparam int CALM_TO     = 280;
    localparam int HOLD_AT     = 400;   // beats sent before the long output hold
    localparam int HOLD_CYCLES = 700;
    localparam int STUCK_LIMIT = 5000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 150;

    // kind 3 is not named in the package; it acts as plain reduction
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam logic [DW-1:0] V_MIN  = 32'h8000_0000;
    localparam logic [DW-1:0] V_MAX  = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] V_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [DW-1:0]       num;
        logic [DW-1:0]       den;
        logic [STATUS_W-1:0] status;
    } fraction_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DW-1:0]     num;
        logic [DW-1:0]     den;
        fraction_t         res;
    } pending_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DW-1:0]     num;
        logic [DW-1:0]     den;
        logic              typed;  // res holds a hand-written result
        fraction_t         res;
    } row_t;

    localparam fraction_t NO_RES   = '{32'd0, 32'd0, STATUS_OK};
    localparam fraction_t ZERO_RES = '{32'd0, 32'd0, STATUS_BOTH_ZERO};
    localparam fraction_t OVF_RES  = '{32'd0, 32'd0, STATUS_OVERFLOW};

    // corner cases: both zero, most negative value, zero denominators, kinds
    localparam row_t DIR_ROWS [N_DIR] = '{
        '{KIND_REDUCE, 32'd6,      32'd4,        1'b0, NO_RES},
        '{KIND_REDUCE, 32'd0,      32'd0,        1'b1, ZERO_RES},
        '{KIND_INVERT, 32'd0,      32'd0,        1'b1, ZERO_RES},
        '{KIND_ABS,    32'd0,      32'd0,        1'b1, ZERO_RES},
        '{KIND_REDUCE, V_MIN,      32'd0,        1'b1, OVF_RES},
        '{KIND_REDUCE, 32'd0,      V_MIN,        1'b1, OVF_RES},
        '{KIND_REDUCE, V_MIN,      V_MIN,        1'b1, OVF_RES},
        '{KIND_REDUCE, V_MIN,      V_ONES,       1'b1, OVF_RES},
        '{KIND_REDUCE, V_MIN,      32'd1,        1'b1, '{V_MIN, 32'd1, STATUS_OK}},
        '{KIND_ABS,    V_MIN,      32'd1,        1'b1, OVF_RES},
        '{KIND_INVERT, 32'd1,      V_MIN,        1'b1, '{V_MIN, 32'd1, STATUS_OK}},
        '{KIND_REDUCE, V_MAX,      V_MAX,        1'b1, '{32'd1, 32'd1, STATUS_OK}},
        '{KIND_REDUCE, V_MAX,      V_ONES,       1'b0, NO_RES},
        '{KIND_INVERT, 32'd0,      32'd5,        1'b1, '{32'd1, 32'd0, STATUS_OK}},
        '{KIND_INVERT, 32'd0,      -32'd5,       1'b1, '{V_ONES, 32'd0, STATUS_OK}},
        '{KIND_REDUCE, 32'd0,      32'd7,        1'b1, '{32'd0, 32'd1, STATUS_OK}},
        '{KIND_REDUCE, 32'd0,      -32'd7,       1'b1, '{32'd0, 32'd1, STATUS_OK}},
        '{KIND_SPARE,  32'd6,      -32'd4,       1'b0, NO_RES},
        '{KIND_ABS,    -32'd12,    32'd8,        1'b0, NO_RES},
        '{KIND_REDUCE, V_ONES,     V_ONES,       1'b1, '{32'd1, 32'd1, STATUS_OK}},
        '{KIND_REDUCE, V_MIN,      32'd2,        1'b0, NO_RES},
        '{KIND_REDUCE, V_MIN,      -32'd2,       1'b0, NO_RES},
        '{KIND_INVERT, -32'd9,     32'd6,        1'b0, NO_RES},
        '{KIND_REDUCE, 32'd5,      32'd0,        1'b0, NO_RES},
        '{KIND_ABS,    V_MAX,      V_MIN + 32'd1, 1'b0, NO_RES}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    pending_t pending_fractions[$];
    int       sent;
    int       received;
    int       fail_count;
    int       stuck_cycles;
    int       kind_count [4];
    int       status_count [4];
    logic     calm;

    assign calm = (sent >= CALM_FROM) && (sent < CALM_TO);

    rational_reduce #(
        .DATA_WIDTH(DW)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // lowest terms of n/d, positive divisor, sign carried by the numerator
    function automatic fraction_t lowest_terms(logic [KIND_W-1:0] k,
                                               logic [DW-1:0] n_in,
                                               logic [DW-1:0] d_in);
        logic [DW-1:0] n, d, an, ad, a, b, t, gm, qn, qd;
        logic          sn, sd, neg;
        fraction_t     r;
        r = NO_RES;
        n = (k == KIND_INVERT) ? d_in : n_in;
        d = (k == KIND_INVERT) ? n_in : d_in;
        sn = n[DW-1];
        sd = d[DW-1];
        an = sn ? (32'd0 - n) : n;
        ad = sd ? (32'd0 - d) : d;
        if (an == 0 && ad == 0) begin
            r.status = STATUS_BOTH_ZERO;
            return r;
        end
        // Euclid; a zero numerator leaves |d| as the divisor
        a = an;
        b = ad;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        gm = a;
        if (gm[DW-1]) begin
            r.status = STATUS_OVERFLOW;
            return r;
        end
        qn = an / gm;
        qd = ad / gm;
        neg = (sn != sd) && (qn != 0) && (k != KIND_ABS);
        if ((!neg && qn[DW-1]) || qd[DW-1]) begin
            r.status = STATUS_OVERFLOW;
            return r;
        end
        r.num = neg ? (32'd0 - qn) : qn;
        r.den = qd;
        return r;
    endfunction

    // random sign on a magnitude
    function automatic logic [DW-1:0] any_sign(logic [DW-1:0] v);
        return $urandom_range(0, 1) ? (32'd0 - v) : v;
    endfunction

    function automatic logic [DW-1:0] edge_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return V_ONES;
            3: return V_MIN;
            4: return V_MAX;
            5: return V_MIN + 32'd1;
            6: return 32'h4000_0000;
            default: return any_sign($urandom_range(1, 64));
        endcase
    endfunction

    task automatic pick_fraction(output logic [KIND_W-1:0] k,
                                 output logic [DW-1:0] n,
                                 output logic [DW-1:0] d);
        logic [DW-1:0] g;
        k = KIND_W'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                // shared factor, so the reduction does real work
                g = $urandom_range(1, 4095);
                n = any_sign(g * $urandom_range(0, 1 << 19));
                d = any_sign(g * $urandom_range(0, 1 << 19));
            end
            4, 5, 6: begin
                n = $urandom;
                d = $urandom;
            end
            7: begin
                n = $urandom_range(0, 1) ? edge_value() : $urandom;
                d = $urandom_range(0, 1) ? edge_value() : $urandom;
            end
            8: begin
                n = any_sign(32'd1 << $urandom_range(0, 31));
                d = any_sign(32'd1 << $urandom_range(0, 31));
            end
            default: begin
                n = any_sign($urandom_range(0, 16));
                d = any_sign($urandom_range(0, 16));
            end
        endcase
    endtask

    // one input beat; called and returns at a falling edge
    task automatic offer_fraction(input logic [KIND_W-1:0] k,
                                  input logic [DW-1:0] n,
                                  input logic [DW-1:0] d,
                                  input logic typed,
                                  input fraction_t typed_res);
        pending_t p;
        if (!calm && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 150)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, n};
        s_tuser  <= k;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p.kind = k;
        p.num  = n;
        p.den  = d;
        p.res  = typed ? typed_res : lowest_terms(k, n, d);
        pending_fractions.push_back(p);
        kind_count[k]++;
        sent++;
        @(negedge aclk);
    endtask

    // stimulus
    initial begin
        logic [KIND_W-1:0] k;
        logic [DW-1:0]     n, d;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        aresetn  = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int i = 0; i < N_DIR; i++) begin
            offer_fraction(DIR_ROWS[i].kind, DIR_ROWS[i].num, DIR_ROWS[i].den,
                           DIR_ROWS[i].typed, DIR_ROWS[i].res);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            pick_fraction(k, n, d);
            offer_fraction(k, n, d, 1'b0, NO_RES);
        end
        s_tvalid <= 1'b0;
        while (pending_fractions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d fractions (%0d table rows), %0d results checked",
                 sent, N_DIR, received);
        $display("kinds reduce/invert/abs/spare %0d/%0d/%0d/%0d, status ok/zero/ovf %0d/%0d/%0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3],
                 status_count[0], status_count[1], status_count[2]);
        if (fail_count == 0) begin
            $display("rational_reduce test passed");
        end else begin
            $display("rational_reduce test failed");
        end
        $finish;
    end

    // result side: random stalls, a calm window, one long hold
    initial begin
        logic held;
        held = 1'b0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!held && sent >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 26);
        end
    end

    // result checker
    always @(posedge aclk) begin
        pending_t  p;
        fraction_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.num    = m_tdata[DW-1:0];
            got.den    = m_tdata[2*DW-1:DW];
            got.status = m_tuser;
            received++;
            status_count[m_tuser]++;
            if (pending_fractions.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat: %0d/%0d status %0d",
                             $signed(got.num), $signed(got.den), got.status);
            end else begin
                p = pending_fractions.pop_front();
                if (got !== p.res) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch kind %0d %0d/%0d: want %0d/%0d st %0d, got %0d/%0d st %0d",
                                 p.kind, $signed(p.num), $signed(p.den),
                                 $signed(p.res.num), $signed(p.res.den), p.res.status,
                                 $signed(got.num), $signed(got.den), got.status);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("no progress for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, pending_fractions.size());
            $display("rational_reduce test failed");
            $finish;
        end
    end

endmodule
